// ===== src/rgbhsv_pkg.sv =====
// ============================================================================
// rgbhsv_pkg
// Shared widths, constants and types for the RGB to HSV converter.
// ============================================================================
package rgbhsv_pkg;

    localparam int COMPONENT_BITS    = 8;
    localparam int HUE_FRACTION_BITS = 6;

    // Hue covers 0 .. 360 degrees in fixed point, so nine integer bits.
    localparam int HUE_W      = 9 + HUE_FRACTION_BITS;
    localparam int HUE_TURN   = 360 << HUE_FRACTION_BITS;
    // Twice the 60 degree scale, since the rounding works on 2*num + delta.
    localparam int HUE_SCALE2 = 120 << HUE_FRACTION_BITS;
    localparam int FULL2      = 2 * ((1 << COMPONENT_BITS) - 1);

    localparam int D_W  = COMPONENT_BITS + 1;
    localparam int U_W  = COMPONENT_BITS + 3;
    localparam int NH_W = HUE_W + COMPONENT_BITS + 1;
    localparam int NS_W = 2 * COMPONENT_BITS + 1;

    localparam int DIV_STAGES = (HUE_W > COMPONENT_BITS) ? HUE_W : COMPONENT_BITS;

    localparam int S_TDATA_W = ((4 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HUE_W + 3 * COMPONENT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_chan;

    // One pixel on its way through the two restoring dividers.
    typedef struct packed {
        logic [NH_W-1:0]           rem_h;
        logic [D_W-1:0]            den_h;
        logic [HUE_W-1:0]          quo_h;
        logic [NS_W-1:0]           rem_s;
        logic [D_W-1:0]            den_s;
        logic [COMPONENT_BITS-1:0] quo_s;
        logic [COMPONENT_BITS-1:0] bright;
        logic [COMPONENT_BITS-1:0] alpha;
    } t_div_item;

endpackage

// ===== src/rgbhsv_div.sv =====
// ============================================================================
// rgbhsv_div
// Pipelined restoring dividers for hue and saturation, one quotient bit
// per stage, both sharing the same stage registers.
// ============================================================================
module rgbhsv_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rgbhsv_pkg::t_div_item i_item,
    output logic                  o_valid,
    output rgbhsv_pkg::t_div_item o_item
);

    localparam int N = rgbhsv_pkg::DIV_STAGES;

    rgbhsv_pkg::t_div_item r_stg [N];
    rgbhsv_pkg::t_div_item n_stg [N];
    rgbhsv_pkg::t_div_item w_src [N];
    logic [N-1:0]          r_vld;

    // Quotient bits enter from the bottom, so stages above a divider's
    // quotient width only shift in leading zeros.
    function automatic rgbhsv_pkg::t_div_item div_step(rgbhsv_pkg::t_div_item x,
                                                       int unsigned bitpos);
        logic [rgbhsv_pkg::NH_W-1:0] dh;
        logic [rgbhsv_pkg::NS_W-1:0] ds;
        logic                        bh;
        logic                        bs;
        rgbhsv_pkg::t_div_item       y;
        y  = x;
        dh = '0;
        ds = '0;
        bh = 1'b0;
        bs = 1'b0;
        if (bitpos < rgbhsv_pkg::HUE_W) begin
            dh = rgbhsv_pkg::NH_W'(x.den_h) << bitpos;
            bh = (x.rem_h >= dh);
        end
        if (bitpos < rgbhsv_pkg::COMPONENT_BITS) begin
            ds = rgbhsv_pkg::NS_W'(x.den_s) << bitpos;
            bs = (x.rem_s >= ds);
        end
        if (bh) begin
            y.rem_h = x.rem_h - dh;
        end
        if (bs) begin
            y.rem_s = x.rem_s - ds;
        end
        y.quo_h = {x.quo_h[rgbhsv_pkg::HUE_W-2:0], bh};
        y.quo_s = {x.quo_s[rgbhsv_pkg::COMPONENT_BITS-2:0], bs};
        return y;
    endfunction

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_src[k] = i_item;
        end else begin : g_next
            assign w_src[k] = r_stg[k-1];
        end
        assign n_stg[k] = div_step(w_src[k], N - 1 - k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_item  = r_stg[N-1];

endmodule

// ===== src/rgb_to_hsv_converter_top.sv =====
// An accepted request reaches the master side through four front stages, one divider
// stage per hue quotient bit and one output register.
// Throughput: one pixel per cycle while the output buffer has room; the hue divider depth sets the latency.
// The pipeline stalls as a whole only while the two-entry output buffer is full.
// Reset (synchronous, active low) clears all valid bits; no data is held over.
// ============================================================================
// rgb_to_hsv_converter_top
// Converts a stream of RGBA pixels into hue, saturation, brightness and alpha.
// ============================================================================
module rgb_to_hsv_converter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // red, green, blue, alpha from the lowest bit up
    input  logic [rgbhsv_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // hue, saturation, brightness, alpha_out from the lowest bit up, zero padded
    output logic [rgbhsv_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int CB = rgbhsv_pkg::COMPONENT_BITS;

    typedef struct packed {
        logic [rgbhsv_pkg::HUE_W-1:0] hue;
        logic [CB-1:0]                sat;
        logic [CB-1:0]                bright;
        logic [CB-1:0]                alpha;
    } t_pix_out;

    logic w_en;

    // Stage 1: channel sort.
    logic [CB-1:0]         w_r, w_g, w_b, w_a;
    logic [CB-1:0]         n_f1_hi, n_f1_lo, w_lo_rg;
    rgbhsv_pkg::t_max_chan n_f1_sel;
    logic                  r_f1_v;
    logic [CB-1:0]         r_f1_hi, r_f1_lo, r_f1_r, r_f1_g, r_f1_b, r_f1_a;
    rgbhsv_pkg::t_max_chan r_f1_sel;

    // Stage 2: delta and signed channel difference.
    logic signed [rgbhsv_pkg::D_W-1:0] n_f2_diff;
    logic [CB-1:0]                     n_f2_delta;
    logic                              r_f2_v;
    logic signed [rgbhsv_pkg::D_W-1:0] r_f2_diff;
    logic [CB-1:0]                     r_f2_delta, r_f2_hi, r_f2_a;
    rgbhsv_pkg::t_max_chan             r_f2_sel;

    // Stage 3: sector offset added, wrapped into one full turn.
    logic [rgbhsv_pkg::U_W-1:0] w_base;
    logic [rgbhsv_pkg::U_W-1:0] n_f3_u;
    logic                       r_f3_v;
    logic [rgbhsv_pkg::U_W-1:0] r_f3_u;
    logic [CB-1:0]              r_f3_delta, r_f3_hi, r_f3_a;

    // Stage 4: rounded dividends.
    rgbhsv_pkg::t_div_item n_f4;
    rgbhsv_pkg::t_div_item r_f4;
    logic                  r_f4_v;

    logic                  w_div_v;
    rgbhsv_pkg::t_div_item w_div;
    t_pix_out              w_fin;

    logic     r_out_v, r_skid_v;
    t_pix_out r_out, r_skid;

    // The whole pipeline moves while the skid entry is free.
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    // ---------------- stage 1 ----------------
    assign w_r = i_s_tdata[CB-1:0];
    assign w_g = i_s_tdata[2*CB-1:CB];
    assign w_b = i_s_tdata[3*CB-1:2*CB];
    assign w_a = i_s_tdata[4*CB-1:3*CB];

    always_comb begin
        priority if (w_r >= w_g && w_r >= w_b) begin
            n_f1_sel = rgbhsv_pkg::MAX_RED;
            n_f1_hi  = w_r;
        end else if (w_g >= w_b) begin
            n_f1_sel = rgbhsv_pkg::MAX_GREEN;
            n_f1_hi  = w_g;
        end else begin
            n_f1_sel = rgbhsv_pkg::MAX_BLUE;
            n_f1_hi  = w_b;
        end
        w_lo_rg = (w_r < w_g) ? w_r : w_g;
        n_f1_lo = (w_b < w_lo_rg) ? w_b : w_lo_rg;
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        n_f2_delta = r_f1_hi - r_f1_lo;
        unique case (r_f1_sel)
            rgbhsv_pkg::MAX_RED: begin
                n_f2_diff = $signed({1'b0, r_f1_g}) - $signed({1'b0, r_f1_b});
            end
            rgbhsv_pkg::MAX_GREEN: begin
                n_f2_diff = $signed({1'b0, r_f1_b}) - $signed({1'b0, r_f1_r});
            end
            rgbhsv_pkg::MAX_BLUE: begin
                n_f2_diff = $signed({1'b0, r_f1_r}) - $signed({1'b0, r_f1_g});
            end
            default: begin
                n_f2_diff = '0;
            end
        endcase
    end

    // ---------------- stage 3 ----------------
    // Only a negative value in the red sector needs a wrap, which adds six deltas.
    always_comb begin
        unique case (r_f2_sel)
            rgbhsv_pkg::MAX_RED: begin
                w_base = r_f2_diff[rgbhsv_pkg::D_W-1]
                       ? (rgbhsv_pkg::U_W'(r_f2_delta) << 2) + (rgbhsv_pkg::U_W'(r_f2_delta) << 1)
                       : '0;
            end
            rgbhsv_pkg::MAX_GREEN: begin
                w_base = rgbhsv_pkg::U_W'(r_f2_delta) << 1;
            end
            rgbhsv_pkg::MAX_BLUE: begin
                w_base = rgbhsv_pkg::U_W'(r_f2_delta) << 2;
            end
            default: begin
                w_base = '0;
            end
        endcase
        n_f3_u = w_base + rgbhsv_pkg::U_W'(r_f2_diff);
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        n_f4.rem_h  = rgbhsv_pkg::NH_W'(r_f3_u) * rgbhsv_pkg::NH_W'(rgbhsv_pkg::HUE_SCALE2)
                    + rgbhsv_pkg::NH_W'(r_f3_delta);
        n_f4.den_h  = {r_f3_delta, 1'b0};
        n_f4.quo_h  = '0;
        n_f4.rem_s  = rgbhsv_pkg::NS_W'(r_f3_delta) * rgbhsv_pkg::NS_W'(rgbhsv_pkg::FULL2)
                    + rgbhsv_pkg::NS_W'(r_f3_hi);
        n_f4.den_s  = {r_f3_hi, 1'b0};
        n_f4.quo_s  = '0;
        n_f4.bright = r_f3_hi;
        n_f4.alpha  = r_f3_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_s_tvalid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_hi    <= n_f1_hi;
            r_f1_lo    <= n_f1_lo;
            r_f1_sel   <= n_f1_sel;
            r_f1_r     <= w_r;
            r_f1_g     <= w_g;
            r_f1_b     <= w_b;
            r_f1_a     <= w_a;
            r_f2_diff  <= n_f2_diff;
            r_f2_delta <= n_f2_delta;
            r_f2_sel   <= r_f1_sel;
            r_f2_hi    <= r_f1_hi;
            r_f2_a     <= r_f1_a;
            r_f3_u     <= n_f3_u;
            r_f3_delta <= r_f2_delta;
            r_f3_hi    <= r_f2_hi;
            r_f3_a     <= r_f2_a;
            r_f4       <= n_f4;
        end
    end

    rgbhsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f4_v),
        .i_item  (r_f4),
        .o_valid (w_div_v),
        .o_item  (w_div)
    );

    // Grey pixels have a zero hue divisor and black pixels a zero saturation
    // divisor; both results are forced to zero. A hue that rounds up to a
    // full turn wraps to zero.
    always_comb begin
        if (w_div.den_h == '0 ||
            w_div.quo_h == rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_TURN)) begin
            w_fin.hue = '0;
        end else begin
            w_fin.hue = w_div.quo_h;
        end
        w_fin.sat    = (w_div.den_s == '0) ? '0 : w_div.quo_s;
        w_fin.bright = w_div.bright;
        w_fin.alpha  = w_div.alpha;
    end

    // ---------------- output register with skid entry ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_div_v;
            end
        end else if (w_en && w_div_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out <= r_skid_v ? r_skid : w_fin;
        end else if (w_en && w_div_v) begin
            r_skid <= w_fin;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = rgbhsv_pkg::M_TDATA_W'({r_out.alpha, r_out.bright, r_out.sat, r_out.hue});

`ifndef SYNTHESIS
    a_hue_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.hue < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_TURN)))
        else $error("hue outside one full turn");

    a_black_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.bright == '0) |-> (r_out.hue == '0 && r_out.sat == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full while output register is empty");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready))
        else $error("skid entry filled without a stalled output");
`endif

endmodule
